### src/baro_temp_pressure_compensation_macros.svh
// Assertion macros for the compensation block.
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH
`ifndef SYNTH
`define BTPC_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define BTPC_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define BTPC_ASSERT_IMPL(label, clk, rst, a, c)
`define BTPC_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

### src/btpc_pkg.sv
package btpc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] REG_T1 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_T2 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_T3 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_P1 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_P2_5 = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_P6_9 = 3'd5;

  // Divider pipeline depth: one quotient bit per stage.
  localparam int unsigned DivBits = 64;

  typedef struct packed {
    logic [19:0] temp_adc;
    logic [19:0] press_adc;
  } in_t;

  typedef struct packed {
    logic signed [31:0] temp_centideg;
    logic [31:0] press_q24_8;
    logic div_zero;
  } out_t;

endpackage

### src/baro_temp_pressure_compensation.sv
// Barometric temperature and pressure compensation, fully pipelined.
// Input: pulse start with in_data (raw temperature and pressure) while busy
// is low; busy is always low, so one beat may enter every cycle.
// Output: done is high for one cycle with out_data; the receiver cannot stall
// and each result is taken in the cycle it appears.
// Calibration: write cfg_we with cfg_index and cfg_data; registers 0..5 as
// in the register map, unknown indexes ignored. Write only while idle.
// Pipeline: after the edge that accepts start, each item passes through
// 9 front stages for the temperature and pressure coefficients, 64 stages of
// the restoring divider (one quotient bit per stage), and 6 back stages for
// the final terms, and then done rises.
// Throughput: one item per cycle; set by the fully pipelined divider.
// Reset: synchronous; clears every valid bit and all calibration registers to
// zero. Items in flight at reset are dropped.
`include "baro_temp_pressure_compensation_macros.svh"
module baro_temp_pressure_compensation (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  btpc_pkg::in_t                      in_data,
  output logic                               done,
  output btpc_pkg::out_t                     out_data,
  input  logic                               cfg_we,
  input  logic [btpc_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [btpc_pkg::CfgDataW-1:0]      cfg_data
);

  logic [15:0] t1;
  logic signed [15:0] t2, t3;
  logic [15:0] p1;
  logic [63:0] p25, p69;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1 <= '0; t2 <= '0; t3 <= '0; p1 <= '0; p25 <= '0; p69 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        btpc_pkg::REG_T1: t1 <= cfg_data[15:0];
        btpc_pkg::REG_T2: t2 <= cfg_data[15:0];
        btpc_pkg::REG_T3: t3 <= cfg_data[15:0];
        btpc_pkg::REG_P1: p1 <= cfg_data[15:0];
        btpc_pkg::REG_P2_5: p25 <= cfg_data;
        btpc_pkg::REG_P6_9: p69 <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [63:0] cp2, cp3, cp4, cp5, cp6, cp7, cp8, cp9;
  assign cp2 = 64'(signed'(p25[15:0]));
  assign cp3 = 64'(signed'(p25[31:16]));
  assign cp4 = 64'(signed'(p25[47:32]));
  assign cp5 = 64'(signed'(p25[63:48]));
  assign cp6 = 64'(signed'(p69[15:0]));
  assign cp7 = 64'(signed'(p69[31:16]));
  assign cp8 = 64'(signed'(p69[47:32]));
  assign cp9 = 64'(signed'(p69[63:48]));

  assign busy = 1'b0;

  // Front stage 1: temperature differences.
  logic v1q;
  logic [31:0] s1a, s1b;
  logic [19:0] s1p;
  always_ff @(posedge clk) begin
    if (rst) v1q <= 1'b0;
    else v1q <= start;
    s1a <= 32'(in_data.temp_adc[19:3]) - {15'd0, t1, 1'b0};
    s1b <= 32'(in_data.temp_adc[19:4]) - {16'd0, t1};
    s1p <= in_data.press_adc;
  end

  // Stage 2: products.
  logic v2q;
  logic [31:0] s2a, s2bb;
  logic [19:0] s2p;
  always_ff @(posedge clk) begin
    if (rst) v2q <= 1'b0;
    else v2q <= v1q;
    s2a <= s1a * 32'(t2);
    s2bb <= s1b * s1b;
    s2p <= s1p;
  end

  // Stage 3: second-order term times coefficient three.
  logic v3q;
  logic signed [31:0] s3tv1, s3m;
  logic [19:0] s3p;
  always_ff @(posedge clk) begin
    if (rst) v3q <= 1'b0;
    else v3q <= v2q;
    s3tv1 <= signed'(s2a) >>> 11;
    s3m <= (signed'(s2bb) >>> 12) * 32'(t3);
    s3p <= s2p;
  end

  // Stage 4: fine temperature.
  logic v4q;
  logic signed [31:0] s4f;
  logic [19:0] s4p;
  always_ff @(posedge clk) begin
    if (rst) v4q <= 1'b0;
    else v4q <= v3q;
    s4f <= s3tv1 + (s3m >>> 14);
    s4p <= s3p;
  end

  // Stage 5: output temperature and the pressure offset term.
  logic v5q;
  logic signed [31:0] s5t;
  logic signed [63:0] s5v;
  logic [19:0] s5p;
  always_ff @(posedge clk) begin
    if (rst) v5q <= 1'b0;
    else v5q <= v4q;
    s5t <= (s4f * 32'sd5 + 32'sd128) >>> 8;
    s5v <= 64'(s4f) - 64'sd128000;
    s5p <= s4p;
  end

  // Stage 6: square and linear products of the offset term, which is a
  // sign-extended 33-bit value.
  logic v6q;
  logic signed [31:0] s6t;
  logic signed [63:0] s6sq, s6v5, s6v2;
  logic [19:0] s6p;
  always_ff @(posedge clk) begin
    if (rst) v6q <= 1'b0;
    else v6q <= v5q;
    s6t <= s5t;
    s6sq <= s5v * s5v;
    s6v5 <= s5v * cp5;
    s6v2 <= s5v * cp2;
    s6p <= s5p;
  end

  // Stage 7: combine var2 and var1 pieces.
  logic v7q;
  logic signed [31:0] s7t;
  logic signed [63:0] s7v2, s7v1;
  logic [19:0] s7p;
  always_ff @(posedge clk) begin
    if (rst) v7q <= 1'b0;
    else v7q <= v6q;
    s7t <= s6t;
    s7v2 <= s6sq * cp6 + (s6v5 <<< 17) + (cp4 <<< 35);
    s7v1 <= ((s6sq * cp3) >>> 8) + (s6v2 <<< 12);
    s7p <= s6p;
  end

  // Stage 8: divisor and dividend.
  logic v8q;
  logic signed [31:0] s8t;
  logic signed [63:0] s8d, s8n;
  always_ff @(posedge clk) begin
    if (rst) v8q <= 1'b0;
    else v8q <= v7q;
    s8t <= s7t;
    s8d <= ((64'sd1 <<< 47) + s7v1) * signed'(64'(p1)) >>> 33;
    s8n <= (((64'(21'd1048576 - 21'(s7p))) <<< 31) - s7v2) * 64'sd3125;
  end

  // Stage 9: magnitudes and signs.
  logic v9q;
  logic [31:0] s9t;
  logic [63:0] s9na, s9da;
  logic s9neg, s9z;
  always_ff @(posedge clk) begin
    if (rst) v9q <= 1'b0;
    else v9q <= v8q;
    s9t <= s8t;
    s9na <= s8n[63] ? 64'(-s8n) : s8n;
    s9da <= s8d[63] ? 64'(-s8d) : s8d;
    s9neg <= s8n[63] ^ s8d[63];
    s9z <= (s8d == '0);
  end

  logic dv_vld;
  logic [63:0] dq;
  logic [33:0] dtag;
  btpc_div #(.TagW(34)) u_div (
    .clk(clk), .rst(rst), .in_vld(v9q), .num(s9na), .den(s9da),
    .in_tag({s9t, s9neg, s9z}), .out_vld(dv_vld), .quo(dq), .out_tag(dtag)
  );

  // Back stage 1: signed quotient.
  logic b1v, b1z;
  logic [31:0] b1t;
  logic signed [63:0] b1p;
  always_ff @(posedge clk) begin
    if (rst) b1v <= 1'b0;
    else b1v <= dv_vld;
    b1t <= dtag[33:2];
    b1z <= dtag[0];
    b1p <= dtag[1] ? signed'(64'(-dq)) : signed'(dq);
  end

  // Back stage 2: h and the p8 product.
  logic b2v, b2z;
  logic [31:0] b2t;
  logic signed [63:0] b2p, b2h, b2p8;
  always_ff @(posedge clk) begin
    if (rst) b2v <= 1'b0;
    else b2v <= b1v;
    b2t <= b1t; b2z <= b1z; b2p <= b1p;
    b2h <= b1p >>> 13;
    b2p8 <= cp8 * b1p;
  end

  // Back stage 3: p9 * h.
  logic b3v, b3z;
  logic [31:0] b3t;
  logic signed [63:0] b3p, b3h, b3a, b3v2;
  always_ff @(posedge clk) begin
    if (rst) b3v <= 1'b0;
    else b3v <= b2v;
    b3t <= b2t; b3z <= b2z; b3p <= b2p; b3h <= b2h;
    b3a <= cp9 * b2h;
    b3v2 <= b2p8 >>> 19;
  end

  // Back stage 4: times h again, as 32-bit partial products. Only the low
  // 64 bits are kept, so the high-by-high term drops out and the cross terms
  // need only their low words.
  logic b4v, b4z;
  logic [31:0] b4t;
  logic signed [63:0] b4p, b4v2;
  logic [63:0] b4ll;
  logic [31:0] b4lh, b4hl;
  always_ff @(posedge clk) begin
    if (rst) b4v <= 1'b0;
    else b4v <= b3v;
    b4t <= b3t; b4z <= b3z; b4p <= b3p; b4v2 <= b3v2;
    b4ll <= 64'(b3a[31:0]) * 64'(b3h[31:0]);
    b4lh <= b3a[31:0] * b3h[63:32];
    b4hl <= b3a[63:32] * b3h[31:0];
  end

  // Back stage 5: cross terms land in the upper word.
  logic b5v, b5z;
  logic [31:0] b5t;
  logic signed [63:0] b5p, b5v1, b5v2;
  always_ff @(posedge clk) begin
    if (rst) b5v <= 1'b0;
    else b5v <= b4v;
    b5t <= b4t; b5z <= b4z; b5p <= b4p; b5v2 <= b4v2;
    b5v1 <= signed'(b4ll + {b4lh + b4hl, 32'd0}) >>> 25;
  end

  // Back stage 6: final sum and output register.
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= b5v;
    out_data.temp_centideg <= signed'(b5t);
    out_data.div_zero <= b5z;
    if (b5z) begin
      out_data.press_q24_8 <= '0;
    end else begin
      out_data.press_q24_8 <= 32'(((b5p + b5v1 + b5v2) >>> 8) + (cp7 <<< 4));
    end
  end

  `BTPC_ASSERT_IMPL(a_busy_low, clk, rst, 1'b1, !busy)
  `BTPC_ASSERT_NEXT(a_front_vld, clk, rst, start, v1q)
  `BTPC_ASSERT_NEXT(a_back_vld, clk, rst, b5v, done)
  `BTPC_ASSERT_IMPL(a_zero_press, clk, rst, done && out_data.div_zero,
                    out_data.press_q24_8 == '0)

endmodule

### src/btpc_div.sv
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
module btpc_div #(
  parameter int unsigned TagW = 40
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_vld,
  input  logic [63:0]     num,
  input  logic [63:0]     den,
  input  logic [TagW-1:0] in_tag,
  output logic            out_vld,
  output logic [63:0]     quo,
  output logic [TagW-1:0] out_tag
);

  localparam int unsigned N = btpc_pkg::DivBits;

  logic             vld [N+1];
  logic [63:0]      rem [N+1];
  logic [63:0]      qn  [N+1];
  logic [63:0]      dv  [N+1];
  logic [TagW-1:0]  tg  [N+1];

  always_comb begin
    vld[0] = in_vld;
    rem[0] = '0;
    qn[0] = num;
    dv[0] = den;
    tg[0] = in_tag;
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [64:0] sh;
    logic [64:0] diff;
    assign sh = {rem[i], qn[i][63]};
    assign diff = sh - {1'b0, dv[i]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      if (diff[64]) begin
        rem[i+1] <= sh[63:0];
      end else begin
        rem[i+1] <= diff[63:0];
      end
      qn[i+1] <= {qn[i][62:0], ~diff[64]};
      dv[i+1] <= dv[i];
      tg[i+1] <= tg[i];
    end
  end

  assign out_vld = vld[N];
  assign quo = qn[N];
  assign out_tag = tg[N];

endmodule

### test/tb.sv
module tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  btpc_pkg::in_t in_data = '0;
  logic done;
  btpc_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [btpc_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [btpc_pkg::CfgDataW-1:0] cfg_data = '0;

  localparam int Latency = 79;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  baro_temp_pressure_compensation dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_data(in_data),
    .done(done), .out_data(out_data), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  class compensation_scoreboard;
    logic [15:0] t1, t2, t3, p1;
    logic [63:0] p2_5, p6_9;
    btpc_pkg::out_t pending[$];
    int errors;

    function new();
      t1 = '0; t2 = '0; t3 = '0; p1 = '0; p2_5 = '0; p6_9 = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [btpc_pkg::CfgIdxW-1:0] idx, logic [63:0] val);
      case (idx)
        btpc_pkg::REG_T1: t1 = val[15:0];
        btpc_pkg::REG_T2: t2 = val[15:0];
        btpc_pkg::REG_T3: t3 = val[15:0];
        btpc_pkg::REG_P1: p1 = val[15:0];
        btpc_pkg::REG_P2_5: p2_5 = val;
        btpc_pkg::REG_P6_9: p6_9 = val;
        default: ;
      endcase
    endfunction

    function btpc_pkg::out_t compensate(btpc_pkg::in_t item);
      logic signed [31:0] c1, c2, c3, a, b, tv1, tv2, fine;
      logic signed [63:0] q1, q2, q3, q4, q5, q6, q7, q8, q9, v1, v2, p, h, num;
      logic [63:0] ma, mb, mq;
      btpc_pkg::out_t r;
      c1 = {16'd0, t1};
      c2 = {{16{t2[15]}}, t2};
      c3 = {{16{t3[15]}}, t3};
      a = {15'd0, item.temp_adc[19:3]} - (c1 <<< 1);
      tv1 = (a * c2) >>> 11;
      b = {16'd0, item.temp_adc[19:4]} - c1;
      tv2 = (((b * b) >>> 12) * c3) >>> 14;
      fine = tv1 + tv2;
      r.temp_centideg = (fine * 5 + 128) >>> 8;
      q1 = {48'd0, p1};
      q2 = {{48{p2_5[15]}}, p2_5[15:0]};
      q3 = {{48{p2_5[31]}}, p2_5[31:16]};
      q4 = {{48{p2_5[47]}}, p2_5[47:32]};
      q5 = {{48{p2_5[63]}}, p2_5[63:48]};
      q6 = {{48{p6_9[15]}}, p6_9[15:0]};
      q7 = {{48{p6_9[31]}}, p6_9[31:16]};
      q8 = {{48{p6_9[47]}}, p6_9[47:32]};
      q9 = {{48{p6_9[63]}}, p6_9[63:48]};
      v1 = 64'(fine) - 64'sd128000;
      v2 = v1 * v1 * q6;
      v2 = v2 + ((v1 * q5) <<< 17);
      v2 = v2 + (q4 <<< 35);
      v1 = ((v1 * v1 * q3) >>> 8) + ((v1 * q2) <<< 12);
      v1 = (((64'sd1 <<< 47) + v1) * q1) >>> 33;
      r.press_q24_8 = '0;
      r.div_zero = 1'b0;
      if (v1 == 0) begin
        r.div_zero = 1'b1;
      end else begin
        p = 64'sd1048576 - {44'd0, item.press_adc};
        num = ((p <<< 31) - v2) * 64'sd3125;
        ma = num[63] ? -num : num;
        mb = v1[63] ? -v1 : v1;
        mq = ma / mb;
        p = (num[63] != v1[63]) ? -mq : mq;
        h = p >>> 13;
        v1 = (q9 * h * h) >>> 25;
        v2 = (q8 * p) >>> 19;
        p = ((p + v1 + v2) >>> 8) + (q7 <<< 4);
        r.press_q24_8 = p[31:0];
      end
      return r;
    endfunction

    function void note_input(btpc_pkg::in_t item);
      pending.push_back(compensate(item));
    endfunction

    function void check_result(btpc_pkg::out_t got);
      btpc_pkg::out_t want;
      if (pending.size() == 0) begin
        $error("result with nothing pending");
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.temp_centideg !== want.temp_centideg) begin
        $error("temp_centideg expected %0d actual %0d", want.temp_centideg,
               got.temp_centideg);
        errors++;
      end
      if (got.press_q24_8 !== want.press_q24_8) begin
        $error("press_q24_8 expected %h actual %h", want.press_q24_8, got.press_q24_8);
        errors++;
      end
      if (got.div_zero !== want.div_zero) begin
        $error("div_zero expected %b actual %b", want.div_zero, got.div_zero);
        errors++;
      end
    endfunction
  endclass

  compensation_scoreboard sb = new();

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(out_data);
  end

  // The write enable drops for one cycle after every write.
  task automatic write_reg(logic [btpc_pkg::CfgIdxW-1:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Start stays high across back-to-back beats; it drops only for a gap or a drain.
  task automatic send_beat(btpc_pkg::in_t item, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_input(item);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_regs();
    write_reg(btpc_pkg::REG_T1, 64'($urandom_range(20000, 35000)));
    write_reg(btpc_pkg::REG_T2, 64'($urandom_range(20000, 30000)));
    write_reg(btpc_pkg::REG_T3, 64'(-$urandom_range(0, 1000)));
    write_reg(btpc_pkg::REG_P1, 64'($urandom_range(30000, 40000)));
    write_reg(btpc_pkg::REG_P2_5, {16'($urandom_range(0, 1000)),
                                   16'($urandom_range(0, 4000)),
                                   16'($urandom_range(0, 3000)),
                                   16'(-$urandom_range(9000, 12000))});
    write_reg(btpc_pkg::REG_P6_9, {16'($urandom_range(0, 5000)),
                                   16'(-$urandom_range(0, 12000)),
                                   16'($urandom_range(0, 200)),
                                   16'(-$urandom_range(0, 10))});
  endtask

  task automatic wild_regs();
    write_reg(btpc_pkg::REG_T1, {$urandom, $urandom});
    write_reg(btpc_pkg::REG_T2, {$urandom, $urandom});
    write_reg(btpc_pkg::REG_T3, {$urandom, $urandom});
    write_reg(btpc_pkg::REG_P1, {$urandom, $urandom});
    write_reg(btpc_pkg::REG_P2_5, {$urandom, $urandom});
    write_reg(btpc_pkg::REG_P6_9, {$urandom, $urandom});
  endtask

  function automatic btpc_pkg::in_t rand_item();
    btpc_pkg::in_t it;
    it.temp_adc = 20'($urandom);
    it.press_adc = 20'($urandom);
    case ($urandom_range(0, 7))
      0: it.temp_adc = '0;
      1: it.temp_adc = '1;
      2: it.press_adc = '0;
      3: it.press_adc = '1;
      default: ;
    endcase
    return it;
  endfunction

  initial begin
    btpc_pkg::in_t it;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // All-zero calibration gives a zero divisor.
    send_beat('{temp_adc: 20'h0, press_adc: 20'h0}, 0);
    send_beat('{temp_adc: 20'hFFFFF, press_adc: 20'hFFFFF}, 0);
    drain();
    random_regs();
    send_beat('{temp_adc: 20'h0, press_adc: 20'h0}, 0);
    send_beat('{temp_adc: 20'hFFFFF, press_adc: 20'hFFFFF}, 1);
    send_beat('{temp_adc: 20'h80000, press_adc: 20'h60000}, 0);
    send_beat('{temp_adc: 20'h7FFFF, press_adc: 20'h0}, 0);
    drain();
    // Extremes of every register.
    write_reg(btpc_pkg::REG_T1, 64'hFFFF);
    write_reg(btpc_pkg::REG_T2, 64'h8000);
    write_reg(btpc_pkg::REG_T3, 64'h7FFF);
    write_reg(btpc_pkg::REG_P1, 64'hFFFF);
    write_reg(btpc_pkg::REG_P2_5, 64'h8000_7FFF_8000_7FFF);
    write_reg(btpc_pkg::REG_P6_9, 64'h7FFF_8000_7FFF_8000);
    for (int i = 0; i < 8; i++) send_beat(rand_item(), 0);
    drain();
    write_reg(btpc_pkg::REG_P1, 64'h0);
    for (int i = 0; i < 4; i++) send_beat(rand_item(), 0);
    drain();
    for (int phase = 0; phase < 6; phase++) begin
      if (phase % 3 == 2) wild_regs();
      else random_regs();
      for (int i = 0; i < 320; i++) begin
        it = rand_item();
        send_beat(it, (phase == 1) ? 0 : ($urandom_range(0, 3) == 0 ?
                                          $urandom_range(0, 11) : 0));
        // Hold off until the pipeline is empty now and then.
        if (i == 160) drain();
      end
      drain();
    end
    repeat (Latency + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end
endmodule
